// ----- src/fert_pkg.sv -----
`default_nettype none

package fert_pkg;

    // Field widths fixed by the command and result formats.
    localparam int IDX_W     = 10;
    localparam int OFF_W     = 13;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FLAG_W    = 2;

    localparam int DEF_TABLE_ENTRIES = 1024;

    // Bit positions inside an entry's flag pair.
    localparam int FLAG_RESERVED = 0;
    localparam int FLAG_VALID    = 1;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_CLEAR     = 3'd0;
    localparam t_mode MODE_NOP       = 3'd1;
    localparam t_mode MODE_RESERVE   = 3'd2;
    localparam t_mode MODE_PUBLISH   = 3'd3;
    localparam t_mode MODE_HOST_VALID = 3'd4;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_BAD_OFFSET = 2'd1;
    localparam t_status ST_FULL       = 2'd2;
    localparam t_status ST_NOT_READY  = 2'd3;

    localparam t_cfg_idx CFG_BASE  = 2'd0;
    localparam t_cfg_idx CFG_LAST  = 2'd1;
    localparam t_cfg_idx CFG_LIMIT = 2'd2;

    // Configuration as seen by the sequencer; last is already capped to the table size.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [IDX_W-1:0]  last;
        logic [IDX_W-1:0]  limit;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/fdb_entry_reservation_table.sv -----
// Each accepted item gives one result at the output. A reserve probes N entries (1 to
// probe_limit + 1), one probe per cycle off the flag memory's read port; clear writes
// one entry per cycle from index 0 to last. One item is in work at a time; a new item
// is taken the cycle after the previous result moves to the output register.
// After reset the flag memory is swept to zero entry by entry, with the input not ready.
`default_nettype none

module fdb_entry_reservation_table #(
    parameter int TABLE_ENTRIES = fert_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire fert_pkg::t_cfg_idx                i_cfg_index,
    input  wire logic [fert_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Command channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire fert_pkg::t_mode                   i_mode,
    input  wire logic [fert_pkg::OFF_W-1:0]        i_byte_offset,
    input  wire logic                              i_valid_value,
    // Result channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output fert_pkg::t_status                      o_status,
    output logic [fert_pkg::ADDR_W-1:0]            o_entry_address
);

    import fert_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    // Configuration with the last index already limited to the physical table.
    t_cfg               cfg;

    // Flag memory port: bit 0 of each entry is the reserved flag, bit 1 the valid flag.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [FLAG_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [FLAG_W-1:0]  mem_rdata;

    fert_cfg #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The sequencer reads an entry, examines it the next cycle and may write it back. Because
    // only one item is in work and every such write-back ends that item's memory accesses, a
    // read of an entry never overlaps a pending write to it.
    fert_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_byte_offset   (i_byte_offset),
        .i_valid_value   (i_valid_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_entry_address (o_entry_address),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    fert_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- src/fert_ram.sv -----
`default_nettype none

module fert_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/fert_cfg.sv -----
`default_nettype none

module fert_cfg #(
    parameter int TABLE_ENTRIES = fert_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire fert_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [fert_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fert_pkg::t_cfg                     o_cfg
);

    import fert_pkg::*;

    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam int CAP_INT = (TABLE_ENTRIES - 1 < IDX_MAX) ? TABLE_ENTRIES - 1 : IDX_MAX;
    localparam logic [IDX_W-1:0] CAP = IDX_W'(CAP_INT);

    logic [ADDR_W-1:0] r_base;
    logic [IDX_W-1:0]  r_last;
    logic [IDX_W-1:0]  r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_last  <= '0;
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_LAST:  r_last  <= i_cfg_data[IDX_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Indices beyond the physical table are never used.
    always_comb begin
        o_cfg.base  = r_base;
        o_cfg.last  = (r_last < CAP) ? r_last : CAP;
        o_cfg.limit = r_limit;
    end

endmodule

`default_nettype wire

// ----- src/fert_ctrl.sv -----
`default_nettype none

module fert_ctrl #(
    parameter int TABLE_ENTRIES = fert_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fert_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire fert_pkg::t_mode                   i_mode,
    input  wire logic [fert_pkg::OFF_W-1:0]        i_byte_offset,
    input  wire logic                              i_valid_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output fert_pkg::t_status                      o_status,
    output logic [fert_pkg::ADDR_W-1:0]            o_entry_address,
    output logic                                   o_mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       o_mem_waddr,
    output logic [fert_pkg::FLAG_W-1:0]            o_mem_wdata,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       o_mem_raddr,
    input  wire logic [fert_pkg::FLAG_W-1:0]       i_mem_rdata
);

    import fert_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CLEAR  = 7'b0000100,
        S_RD     = 7'b0001000,
        S_PROBE  = 7'b0010000,
        S_FLAG   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_vval, n_vval;
    logic [IDX_W-1:0]    r_probe, n_probe;
    logic [AW-1:0]       r_init, n_init;
    t_status             r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;

    logic                accept;
    logic                off_ok;
    logic [IDX_W-1:0]    in_idx;
    logic [IDX_W-1:0]    wrap_idx;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [AW+IDX_W-1:0] w;
        w = {{AW{1'b0}}, idx};
        return w[AW-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_idx     = i_byte_offset[OFF_W-1:3];
    assign off_ok     = (i_byte_offset[2:0] == 3'b000) && (in_idx <= i_cfg.last);
    assign wrap_idx   = (r_idx == i_cfg.last) ? '0 : r_idx + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_vval       = r_vval;
        n_probe      = r_probe;
        n_init       = r_init;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        o_mem_we     = 1'b0;
        o_mem_waddr  = to_addr(r_idx);
        o_mem_wdata  = '0;
        o_mem_raddr  = to_addr(r_idx);

        case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_init;
                n_init      = r_init + 1'b1;
                if (r_init == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_mode       = i_mode;
                    n_idx        = in_idx;
                    n_vval       = i_valid_value;
                    n_probe      = '0;
                    n_res_status = ST_OK;
                    n_res_addr   = '0;
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        MODE_RESERVE, MODE_PUBLISH, MODE_HOST_VALID: begin
                            if (off_ok) begin
                                n_state = S_RD;
                            end else begin
                                n_res_status = ST_BAD_OFFSET;
                                n_state      = S_RESULT;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_mem_we = 1'b1;
                if (r_idx == i_cfg.last) begin
                    n_state = S_RESULT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RD: begin
                n_state = (r_mode == MODE_RESERVE) ? S_PROBE : S_FLAG;
            end
            S_PROBE: begin
                // The next entry is read while this one is examined.
                o_mem_raddr = to_addr(wrap_idx);
                if (!i_mem_rdata[FLAG_RESERVED]) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata;
                    o_mem_wdata[FLAG_RESERVED] = 1'b1;
                    n_res_addr  = i_cfg.base +
                                  {{(ADDR_W-IDX_W-3){1'b0}}, r_idx, 3'b000};
                    n_state     = S_RESULT;
                end else if (r_probe == i_cfg.limit) begin
                    n_res_status = ST_FULL;
                    n_state      = S_RESULT;
                end else begin
                    n_idx   = wrap_idx;
                    n_probe = r_probe + 1'b1;
                end
            end
            S_FLAG: begin
                if (r_mode == MODE_PUBLISH) begin
                    if (!(i_mem_rdata[FLAG_RESERVED] && i_mem_rdata[FLAG_VALID])) begin
                        n_res_status = ST_NOT_READY;
                    end
                end else begin
                    o_mem_we = 1'b1;
                    o_mem_wdata[FLAG_RESERVED] = i_mem_rdata[FLAG_RESERVED];
                    o_mem_wdata[FLAG_VALID]    = r_vval;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_idx        <= n_idx;
        r_vval       <= n_vval;
        r_probe      <= n_probe;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_address = r_out_addr;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input still ready the cycle after an item was taken");

    a_addr_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_addr == '0))
        else $error("failed command carries a non-zero entry address");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) || (r_state == S_RESULT) || (r_state == S_RD)) |-> !o_mem_we)
        else $error("flag memory written outside a command's write step");

    a_result_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result appeared without passing the result step");

endmodule

`default_nettype wire
